// File: rtl/tcce_pkg.sv
// tcce_pkg: shared types and constants of the text console cursor engine
// used by tcce_ctrl, tcce_datapath and text_console_cursor_engine
package tcce_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam int MODE_W     = 3;
  localparam int CHAR_W     = 8;
  localparam int ROW_W      = 5;
  localparam int COL_W      = 7;
  localparam int POS_W      = 11;
  localparam int STYLE_W    = 8;
  localparam int CELL_W     = CHAR_W + STYLE_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // item modes
  localparam logic [MODE_W-1:0] MODE_PUT   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SET   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_HOME  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_WRITE = 3'd3;
  localparam logic [MODE_W-1:0] MODE_READ  = 3'd4;

  // control bytes
  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_BLANK = 8'h20;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STYLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TAB   = 2'd2;

  localparam logic [STYLE_W-1:0] RESET_STYLE = 8'h0F;
  localparam logic [ROW_W-1:0]   RESET_TOP   = 5'd3;
  localparam logic [ROW_W-1:0]   RESET_TAB   = 5'd4;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_TAB_DIV,
    S_TAB_FILL,
    S_SCR_RD,
    S_SCR_WR,
    S_SCR_BLANK,
    S_RESP
  } ctrl_state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_CLEAR,
    OP_EXEC,
    OP_DIV,
    OP_FILL,
    OP_SCR_RD,
    OP_SCR_WR,
    OP_BLANK,
    OP_RESP
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic is_tab;
    logic scroll_now;
    logic copy_en;
    logic div_last;
    logic fill_last;
    logic ptr_last;
  } dp_stat_t;

endpackage

// File: rtl/tcce_ctrl.sv
// tcce_ctrl: sequencer of the console engine, issues one datapath op per cycle
// depends on tcce_pkg (states, ops, command and status structs)
module tcce_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  output tcce_pkg::dp_cmd_t  cmd_o,
  input  tcce_pkg::dp_stat_t stat_i
);
  import tcce_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    cmd_o.op = OP_NONE;
    busy_o   = 1'b1;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.op = OP_CLEAR;
        if (stat_i.ptr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.op = OP_EXEC;
        priority if (stat_i.is_tab) begin
          state_d = S_TAB_DIV;
        end else if (stat_i.scroll_now) begin
          state_d = stat_i.copy_en ? S_SCR_RD : S_SCR_BLANK;
        end else begin
          state_d = S_RESP;
        end
      end
      S_TAB_DIV: begin
        cmd_o.op = OP_DIV;
        if (stat_i.div_last) state_d = S_TAB_FILL;
      end
      S_TAB_FILL: begin
        cmd_o.op = OP_FILL;
        if (stat_i.fill_last) begin
          priority if (stat_i.scroll_now) begin
            state_d = stat_i.copy_en ? S_SCR_RD : S_SCR_BLANK;
          end else begin
            state_d = S_RESP;
          end
        end
      end
      S_SCR_RD: begin
        cmd_o.op = OP_SCR_RD;
        state_d  = S_SCR_WR;
      end
      S_SCR_WR: begin
        cmd_o.op = OP_SCR_WR;
        state_d  = stat_i.ptr_last ? S_SCR_BLANK : S_SCR_RD;
      end
      S_SCR_BLANK: begin
        cmd_o.op = OP_BLANK;
        if (stat_i.ptr_last) state_d = S_RESP;
      end
      S_RESP: begin
        cmd_o.op = OP_RESP;
        state_d  = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/tcce_datapath.sv
// tcce_datapath: cursor, config registers, screen cell memory and result word
// depends on tcce_pkg; driven op by op from tcce_ctrl
module tcce_datapath #(
  parameter int COLUMNS = tcce_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcce_pkg::ROWS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  tcce_pkg::dp_cmd_t                cmd_i,
  output tcce_pkg::dp_stat_t               stat_o,
  input  logic                             cfg_we_i,
  input  logic [tcce_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [tcce_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic [tcce_pkg::MODE_W-1:0]      mode_i,
  input  logic [tcce_pkg::CHAR_W-1:0]      char_code_i,
  input  logic [tcce_pkg::ROW_W-1:0]       row_i,
  input  logic [tcce_pkg::COL_W-1:0]       col_i,
  output logic                             done_o,
  output logic [tcce_pkg::ROW_W-1:0]       at_row_o,
  output logic [tcce_pkg::COL_W-1:0]       at_col_o,
  output logic [tcce_pkg::POS_W-1:0]       cursor_pos_o,
  output logic [tcce_pkg::CHAR_W-1:0]      read_char_o,
  output logic [tcce_pkg::STYLE_W-1:0]     read_style_o,
  output logic                             scrolled_o
);
  import tcce_pkg::*;

  localparam int EXTENT  = ROWS * COLUMNS;
  localparam int ADDR_W  = $clog2(EXTENT);
  localparam int LIN_RAW = $clog2(32 * COLUMNS + 128);
  localparam int LIN_W   = (LIN_RAW > POS_W) ? LIN_RAW : POS_W;

  localparam logic [ROW_W-1:0]  LAST_ROW    = ROW_W'(ROWS - 1);
  localparam logic [COL_W-1:0]  LAST_COL    = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W:0]    ROWS_X      = (ROW_W + 1)'(ROWS);
  localparam logic [COL_W:0]    COLS_X      = (COL_W + 1)'(COLUMNS);
  localparam logic [LIN_W-1:0]  COLS_L      = LIN_W'(COLUMNS);
  localparam logic [LIN_W-1:0]  EXT_L       = LIN_W'(EXTENT);
  localparam logic [ADDR_W-1:0] COLS_A      = ADDR_W'(COLUMNS);
  localparam logic [ADDR_W-1:0] LAST_ADDR   = ADDR_W'(EXTENT - 1);
  localparam logic [ADDR_W-1:0] BLANK_START = ADDR_W'((ROWS - 1) * COLUMNS);

  // configuration
  logic [STYLE_W-1:0] style_q;
  logic [ROW_W-1:0]   top_q;
  logic [ROW_W-1:0]   tab_q;

  // latched item
  logic [MODE_W-1:0]  mode_q;
  logic [CHAR_W-1:0]  char_q;
  logic [ROW_W-1:0]   row_in_q;
  logic [COL_W-1:0]   col_in_q;

  // cursor and sequencing state
  logic [ROW_W-1:0]   cur_row_q, cur_row_d;
  logic [COL_W-1:0]   cur_col_q, cur_col_d;
  logic [ADDR_W-1:0]  ptr_q, ptr_d;
  logic [5:0]         rem_q, rem_d;
  logic [2:0]         bit_q, bit_d;
  logic               scr_q, scr_d;
  logic               rd_ok_q, rd_ok_d;
  logic               done_q, done_d;

  // screen store
  logic [CELL_W-1:0]  mem [EXTENT];
  logic [CELL_W-1:0]  rd_data_q;
  logic               mem_we, mem_re;
  logic [ADDR_W-1:0]  waddr, raddr;
  logic [CELL_W-1:0]  wdata;

  // result word
  logic [ROW_W-1:0]   res_row_q;
  logic [COL_W-1:0]   res_col_q;
  logic [POS_W-1:0]   res_pos_q;
  logic [CHAR_W-1:0]  res_char_q;
  logic [STYLE_W-1:0] res_style_q;
  logic               res_scr_q;

  logic               load, res_load, adv;
  logic [ROW_W-1:0]   tw_eff;
  logic [ROW_W-1:0]   floor_row;
  logic               copy_en;
  logic [LIN_W-1:0]   cur_lin, in_lin, copy_lin;
  logic [ADDR_W-1:0]  cur_addr, in_addr, scr_start;
  logic               in_ok;
  logic [5:0]         rem_sh, rem_nx;

  assign tw_eff    = (tab_q == '0) ? ROW_W'(1) : tab_q;
  assign floor_row = ({1'b0, top_q} < ROWS_X) ? top_q : LAST_ROW;
  assign copy_en   = (({1'b0, top_q} + (ROW_W + 1)'(1)) < ROWS_X);

  assign cur_lin   = LIN_W'(cur_row_q) * COLS_L + LIN_W'(cur_col_q);
  assign cur_addr  = cur_lin[ADDR_W-1:0];
  assign in_lin    = LIN_W'(row_in_q) * COLS_L + LIN_W'(col_in_q);
  assign in_ok     = (in_lin < EXT_L);
  assign in_addr   = in_lin[ADDR_W-1:0];
  assign copy_lin  = (LIN_W'(top_q) + LIN_W'(1)) * COLS_L;
  assign scr_start = copy_en ? copy_lin[ADDR_W-1:0] : BLANK_START;

  // one bit of cur_col mod tab width per step
  assign rem_sh = {rem_q[4:0], cur_col_q[bit_q]};
  assign rem_nx = (rem_sh >= {1'b0, tw_eff}) ? (rem_sh - {1'b0, tw_eff}) : rem_sh;

  always_comb begin
    cur_row_d = cur_row_q;
    cur_col_d = cur_col_q;
    ptr_d     = ptr_q;
    rem_d     = rem_q;
    bit_d     = bit_q;
    scr_d     = scr_q;
    rd_ok_d   = rd_ok_q;
    done_d    = 1'b0;
    load      = 1'b0;
    res_load  = 1'b0;
    adv       = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    waddr     = cur_addr;
    raddr     = ptr_q;
    wdata     = {style_q, CH_BLANK};
    unique case (cmd_i.op)
      OP_NONE: begin
      end
      OP_LOAD: begin
        load    = 1'b1;
        scr_d   = 1'b0;
        rd_ok_d = 1'b0;
      end
      OP_CLEAR: begin
        mem_we = 1'b1;
        waddr  = ptr_q;
        wdata  = {RESET_STYLE, CH_BLANK};
        ptr_d  = (ptr_q == LAST_ADDR) ? '0 : ptr_q + ADDR_W'(1);
      end
      OP_EXEC: begin
        unique case (mode_q)
          MODE_PUT: begin
            unique case (char_q)
              CH_NL: begin
                cur_col_d = '0;
                adv       = 1'b1;
              end
              CH_BS: begin
                // previous cell is cur_addr - 1 also when wrapping back a row
                if (cur_col_q != '0 || cur_row_q > floor_row) begin
                  mem_we = 1'b1;
                  waddr  = cur_addr - ADDR_W'(1);
                  if (cur_col_q != '0) begin
                    cur_col_d = cur_col_q - COL_W'(1);
                  end else begin
                    cur_row_d = cur_row_q - ROW_W'(1);
                    cur_col_d = LAST_COL;
                  end
                end
              end
              CH_TAB: begin
                rem_d = '0;
                bit_d = 3'(COL_W - 1);
              end
              default: begin
                mem_we = 1'b1;
                wdata  = {style_q, char_q};
                if (cur_col_q == LAST_COL) begin
                  cur_col_d = '0;
                  adv       = 1'b1;
                end else begin
                  cur_col_d = cur_col_q + COL_W'(1);
                end
              end
            endcase
          end
          MODE_SET: begin
            if ({1'b0, row_in_q} < ROWS_X) cur_row_d = row_in_q;
            if ({1'b0, col_in_q} < COLS_X) cur_col_d = col_in_q;
          end
          MODE_HOME: begin
            cur_row_d = floor_row;
            cur_col_d = '0;
          end
          MODE_WRITE: begin
            if (in_ok) begin
              mem_we = 1'b1;
              waddr  = in_addr;
              wdata  = {style_q, char_q};
            end
          end
          MODE_READ: begin
            if (in_ok) begin
              mem_re  = 1'b1;
              raddr   = in_addr;
              rd_ok_d = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      OP_DIV: begin
        rem_d = rem_nx;
        bit_d = bit_q - 3'd1;
      end
      OP_FILL: begin
        mem_we = 1'b1;
        rem_d  = rem_q + 6'd1;
        if (cur_col_q == LAST_COL) begin
          cur_col_d = '0;
          adv       = 1'b1;
        end else begin
          cur_col_d = cur_col_q + COL_W'(1);
        end
      end
      OP_SCR_RD: begin
        mem_re = 1'b1;
      end
      OP_SCR_WR: begin
        mem_we = 1'b1;
        waddr  = ptr_q - COLS_A;
        wdata  = rd_data_q;
        ptr_d  = (ptr_q == LAST_ADDR) ? BLANK_START : ptr_q + ADDR_W'(1);
      end
      OP_BLANK: begin
        mem_we = 1'b1;
        waddr  = ptr_q;
        ptr_d  = (ptr_q == LAST_ADDR) ? '0 : ptr_q + ADDR_W'(1);
      end
      OP_RESP: begin
        res_load = 1'b1;
        done_d   = 1'b1;
      end
      default: begin
      end
    endcase

    // moving past the last row keeps the cursor there and starts a scroll
    if (adv) begin
      if (cur_row_q == LAST_ROW) begin
        scr_d = 1'b1;
        ptr_d = scr_start;
      end else begin
        cur_row_d = cur_row_q + ROW_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      style_q   <= RESET_STYLE;
      top_q     <= RESET_TOP;
      tab_q     <= RESET_TAB;
      cur_row_q <= RESET_TOP;
      cur_col_q <= '0;
      ptr_q     <= '0;
      rem_q     <= '0;
      bit_q     <= '0;
      scr_q     <= 1'b0;
      rd_ok_q   <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      cur_row_q <= cur_row_d;
      cur_col_q <= cur_col_d;
      ptr_q     <= ptr_d;
      rem_q     <= rem_d;
      bit_q     <= bit_d;
      scr_q     <= scr_d;
      rd_ok_q   <= rd_ok_d;
      done_q    <= done_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_STYLE: style_q <= cfg_data_i;
          CFG_TOP:   top_q   <= cfg_data_i[ROW_W-1:0];
          CFG_TAB:   tab_q   <= cfg_data_i[ROW_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      mode_q   <= mode_i;
      char_q   <= char_code_i;
      row_in_q <= row_i;
      col_in_q <= col_i;
    end
    if (res_load) begin
      res_row_q   <= cur_row_q;
      res_col_q   <= cur_col_q;
      res_pos_q   <= cur_lin[POS_W-1:0];
      res_char_q  <= rd_ok_q ? rd_data_q[CHAR_W-1:0] : '0;
      res_style_q <= rd_ok_q ? rd_data_q[CELL_W-1:CHAR_W] : '0;
      res_scr_q   <= scr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[waddr] <= wdata;
    if (mem_re) rd_data_q <= mem[raddr];
  end

  assign stat_o.is_tab     = (mode_q == MODE_PUT) && (char_q == CH_TAB);
  assign stat_o.scroll_now = adv && (cur_row_q == LAST_ROW);
  assign stat_o.copy_en    = copy_en;
  assign stat_o.div_last   = (bit_q == '0);
  assign stat_o.fill_last  = ((rem_q + 6'd1) == {1'b0, tw_eff}) || (cur_col_q == LAST_COL);
  assign stat_o.ptr_last   = (ptr_q == LAST_ADDR);

  assign done_o       = done_q;
  assign at_row_o     = res_row_q;
  assign at_col_o     = res_col_q;
  assign cursor_pos_o = res_pos_q;
  assign read_char_o  = res_char_q;
  assign read_style_o = res_style_q;
  assign scrolled_o   = res_scr_q;

  a_done_after_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(cmd_i.op == OP_RESP))
    else $error("result strobe without a response step");

  a_copy_below_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_SCR_WR) |-> (ptr_q >= COLS_A))
    else $error("scroll copy source on the first row");

  a_fill_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_FILL) |-> (rem_q < {1'b0, tw_eff}))
    else $error("tab fill ran past the tab stop");

  a_read_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && !$past(rd_ok_q)) |-> (res_char_q == '0 && res_style_q == '0))
    else $error("read fields nonzero without a cell read");

endmodule

// File: rtl/text_console_cursor_engine.sv
// text_console_cursor_engine: top level of the teletype console engine
// depends on tcce_pkg, tcce_ctrl and tcce_datapath
//
// usage: an item (mode, char_code, row, col) is taken at a rising edge with
//   start_i high and busy_o low. each item gives one result word, shown for
//   exactly one cycle with done_o high; the receiver cannot stall it.
// config: cfg_valid_i with cfg_index_i/cfg_data_i writes cell_style (0),
//   top_row (1) or tab spacing (2); cfg_ready_o is always high. write only
//   while the engine is idle.
// sequence: a plain item runs an execute step and a response step, then
//   done_o rises with the result word.
//   busy_o drops again while done_o is high, so the next item can be taken.
// tab: plus the division steps for the remainder of the column by the tab
//   width (one bit a step) and one fill step per blank cell written.
// scroll: plus a read and a write step per cell moved up over the
//   single-port-pair cell memory, then blank steps for the bottom row.
// reset: the cursor goes to row 3 column 0 and a clearing pass writes blanks
//   with style 0x0F to all ROWS*COLUMNS cells, busy meanwhile; config writes
//   are taken during the pass.
module text_console_cursor_engine #(
  parameter int COLUMNS = tcce_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcce_pkg::ROWS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [tcce_pkg::MODE_W-1:0]     mode_i,
  input  logic [tcce_pkg::CHAR_W-1:0]     char_code_i,
  input  logic [tcce_pkg::ROW_W-1:0]      row_i,
  input  logic [tcce_pkg::COL_W-1:0]      col_i,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [tcce_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tcce_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic                            done_o,
  output logic [tcce_pkg::ROW_W-1:0]      at_row_o,
  output logic [tcce_pkg::COL_W-1:0]      at_col_o,
  output logic [tcce_pkg::POS_W-1:0]      cursor_pos_o,
  output logic [tcce_pkg::CHAR_W-1:0]     read_char_o,
  output logic [tcce_pkg::STYLE_W-1:0]    read_style_o,
  output logic                            scrolled_o
);
  import tcce_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready_o = 1'b1;

  tcce_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .cmd_o  (cmd),
    .stat_i (stat)
  );

  tcce_datapath #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .mode_i      (mode_i),
    .char_code_i (char_code_i),
    .row_i       (row_i),
    .col_i       (col_i),
    .done_o      (done_o),
    .at_row_o    (at_row_o),
    .at_col_o    (at_col_o),
    .cursor_pos_o(cursor_pos_o),
    .read_char_o (read_char_o),
    .read_style_o(read_style_o),
    .scrolled_o  (scrolled_o)
  );

endmodule
